// File: hdl/gmpst_pkg.sv
// ----------------------------------------------------------------------------
// gmpst_pkg: shared types and constants for the grid min path sum block
// Cost and backpointer types, field widths and register indexes used by the
// sweep front end, the job queue and the traceback back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gmpst_pkg;

	// default grid limits
	localparam int MAX_ROWS_DEF = 16;
	localparam int MAX_COLS_DEF = 16;

	// field widths
	localparam int CELL_W      = 16;
	localparam int COST_W      = 21;
	localparam int COORD_W     = 4;
	localparam int CFG_W       = 5;
	localparam int CFG_IDX_W   = 1;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 32;

	// size register value after reset
	localparam int SIZE_RESET = 16;

	// job queue depth, power of two
	localparam int QUEUE_DEPTH = 2;

	typedef logic signed [COST_W-1:0] cost_t;

	// backpointer codes, code 3 never written and ends a trace like origin
	typedef enum logic [1:0] {
		BP_NONE = 2'd0,
		BP_LEFT = 2'd1,
		BP_UP   = 2'd2
	} bp_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NUM_ROWS = 1'b0,
		REG_NUM_COLS = 1'b1
	} cfg_reg_t;

endpackage

// File: hdl/gmpst_front.sv
// ----------------------------------------------------------------------------
// gmpst_front: row-major cost sweep
// Takes one cell per cycle while s_tready is high, adds the cheaper of the
// up and left costs, writes the backpointer, queues a job at the last cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gmpst_front #(
	parameter int MAX_ROWS = gmpst_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = gmpst_pkg::MAX_COLS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration writes
	input  logic                                  cfg_we,
	input  logic [gmpst_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [gmpst_pkg::CFG_W-1:0]           cfg_data,
	// cell stream, tdata: cell_value
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [gmpst_pkg::IN_TDATA_W-1:0]      s_tdata,
	// job to the back end
	output logic                                  job_valid,
	input  logic                                  job_ready,
	output gmpst_pkg::cost_t                      job_cost,
	output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] job_row,
	output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] job_col,
	input  logic                                  trace_done,
	// backpointer write port
	output logic                                  bp_we,
	output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)
		+ ((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] bp_addr,
	output gmpst_pkg::bp_t                        bp_code
);

	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int ROWS_RST = ((gmpst_pkg::SIZE_RESET < MAX_ROWS) ?
		gmpst_pkg::SIZE_RESET : MAX_ROWS) - 1;
	localparam int COLS_RST = ((gmpst_pkg::SIZE_RESET < MAX_COLS) ?
		gmpst_pkg::SIZE_RESET : MAX_COLS) - 1;

	logic [RW-1:0] rows_last_q;
	logic [CW-1:0] cols_last_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic          hold_q;
	gmpst_pkg::cost_t left_q;
	gmpst_pkg::cost_t up_q;
	gmpst_pkg::cost_t rcb_mem [MAX_COLS];

	logic [RW-1:0] rows_new;
	logic [CW-1:0] cols_new;
	logic          accept;
	logic          last_col;
	logic          last_row;
	logic [CW-1:0] next_col;
	gmpst_pkg::cost_t cell_ext;
	gmpst_pkg::cost_t base;
	gmpst_pkg::cost_t cost;
	gmpst_pkg::bp_t   code;

	// clamp written sizes to 1..max, kept as last index
	always_comb begin
		if (cfg_data == '0) begin
			rows_new = '0;
		end else if (int'(cfg_data) > MAX_ROWS) begin
			rows_new = RW'(MAX_ROWS - 1);
		end else begin
			rows_new = RW'(cfg_data - gmpst_pkg::CFG_W'(1));
		end
		if (cfg_data == '0) begin
			cols_new = '0;
		end else if (int'(cfg_data) > MAX_COLS) begin
			cols_new = CW'(MAX_COLS - 1);
		end else begin
			cols_new = CW'(cfg_data - gmpst_pkg::CFG_W'(1));
		end
	end

	// handshake and position
	assign s_tready = !hold_q && job_ready;
	assign accept   = s_tvalid && s_tready;
	assign last_col = (col_q == cols_last_q);
	assign last_row = (row_q == rows_last_q);
	assign next_col = last_col ? '0 : col_q + CW'(1);

	// pick neighbor and add the cell
	always_comb begin
		cell_ext = gmpst_pkg::cost_t'({{(gmpst_pkg::COST_W - gmpst_pkg::CELL_W)
			{s_tdata[gmpst_pkg::CELL_W-1]}}, s_tdata[gmpst_pkg::CELL_W-1:0]});
		if (row_q == '0 && col_q == '0) begin
			base = '0;
			code = gmpst_pkg::BP_NONE;
		end else if (row_q == '0) begin
			base = left_q;
			code = gmpst_pkg::BP_LEFT;
		end else if (col_q == '0) begin
			base = up_q;
			code = gmpst_pkg::BP_UP;
		end else if (up_q < left_q) begin
			base = up_q;
			code = gmpst_pkg::BP_UP;
		end else begin
			base = left_q;
			code = gmpst_pkg::BP_LEFT;
		end
		cost = base + cell_ext;
	end

	// backpointer write and job hand-off
	assign bp_we     = accept;
	assign bp_addr   = {row_q, col_q};
	assign bp_code   = code;
	assign job_valid = accept && last_col && last_row;
	assign job_cost  = cost;
	assign job_row   = row_q;
	assign job_col   = col_q;

	// sizes, position and hold while the back end reads backpointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_last_q <= RW'(ROWS_RST);
			cols_last_q <= CW'(COLS_RST);
			row_q       <= '0;
			col_q       <= '0;
			hold_q      <= 1'b0;
		end else begin
			if (trace_done) begin
				hold_q <= 1'b0;
			end
			if (cfg_we) begin
				case (gmpst_pkg::cfg_reg_t'(cfg_index))
					gmpst_pkg::REG_NUM_ROWS: rows_last_q <= rows_new;
					gmpst_pkg::REG_NUM_COLS: cols_last_q <= cols_new;
					default: ;
				endcase
				row_q <= '0;
				col_q <= '0;
			end else if (accept) begin
				col_q <= next_col;
				if (last_col) begin
					row_q <= last_row ? '0 : row_q + RW'(1);
				end
				if (last_col && last_row) begin
					hold_q <= 1'b1;
				end
			end
		end
	end

	// row cost buffer, up cost fetched one cell ahead
	always_ff @(posedge clk) begin
		if (accept) begin
			rcb_mem[col_q] <= cost;
			left_q         <= cost;
			if (next_col == col_q) begin
				up_q <= cost;
			end else begin
				up_q <= rcb_mem[next_col];
			end
		end
	end

endmodule

// File: hdl/gmpst_queue.sv
// ----------------------------------------------------------------------------
// gmpst_queue: job queue between front and back
// Small first-in first-out buffer of finished-grid jobs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gmpst_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PW = (gmpst_pkg::QUEUE_DEPTH > 1) ? $clog2(gmpst_pkg::QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(gmpst_pkg::QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] entry_q [gmpst_pkg::QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != NW'(gmpst_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + NW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: hdl/gmpst_back.sv
// ----------------------------------------------------------------------------
// gmpst_back: traceback and path emission
// Holds the backpointer store, walks back from the corner onto a path stack,
// then sends the stack out from the origin to the corner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gmpst_back #(
	parameter int MAX_ROWS = gmpst_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = gmpst_pkg::MAX_COLS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// backpointer write port
	input  logic                                  bp_we,
	input  logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)
		+ ((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] bp_addr,
	input  gmpst_pkg::bp_t                        bp_code,
	// job from the queue
	input  logic                                  job_valid,
	output logic                                  job_ready,
	input  gmpst_pkg::cost_t                      job_cost,
	input  logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] job_row,
	input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] job_col,
	output logic                                  trace_done,
	// path stream
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [gmpst_pkg::COORD_W-1:0]         out_row,
	output logic [gmpst_pkg::COORD_W-1:0]         out_col,
	output gmpst_pkg::cost_t                      out_cost,
	output logic                                  out_last
);

	localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int BPD = 2 ** (RW + CW);
	localparam int PD  = MAX_ROWS + MAX_COLS - 1;
	localparam int PDW = (PD > 1) ? $clog2(PD) : 1;
	localparam int DCW = $clog2(PD + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TRACE_RD,
		ST_TRACE_CHK,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

	state_t              state_q;
	logic [RW-1:0]       tr_q;
	logic [CW-1:0]       tc_q;
	gmpst_pkg::cost_t    total_q;
	logic [DCW-1:0]      depth_q;
	logic [PDW-1:0]      idx_q;
	logic                trace_done_q;
	logic                m_tvalid_q;
	logic [gmpst_pkg::COORD_W-1:0] out_row_q;
	logic [gmpst_pkg::COORD_W-1:0] out_col_q;
	gmpst_pkg::cost_t    out_cost_q;
	logic                out_last_q;

	gmpst_pkg::bp_t      bp_mem [BPD];
	gmpst_pkg::bp_t      bp_rd_q;
	logic [RW+CW-1:0]    stack_mem [PD];
	logic [RW+CW-1:0]    stack_rd_q;

	logic                step_up;
	logic                step_left;
	logic                room;
	logic                trace_end;

	assign job_ready  = (state_q == ST_IDLE);
	assign trace_done = trace_done_q;
	assign m_tvalid   = m_tvalid_q;
	assign out_row    = out_row_q;
	assign out_col    = out_col_q;
	assign out_cost   = out_cost_q;
	assign out_last   = out_last_q;

	// next traceback move
	assign step_up   = (bp_rd_q == gmpst_pkg::BP_UP) && (tr_q != '0);
	assign step_left = (bp_rd_q == gmpst_pkg::BP_LEFT) && (tc_q != '0);
	assign room      = (depth_q != DCW'(PD));
	assign trace_end = (state_q == ST_TRACE_CHK) && !(room && (step_up || step_left));

	// backpointer store, registered read at the trace position
	always_ff @(posedge clk) begin
		if (bp_we) begin
			bp_mem[bp_addr] <= bp_code;
		end
		bp_rd_q <= bp_mem[{tr_q, tc_q}];
	end

	// path stack, pushed during trace and read back in reverse
	always_ff @(posedge clk) begin
		if (state_q == ST_TRACE_RD) begin
			stack_mem[depth_q[PDW-1:0]] <= {tr_q, tc_q};
		end
		stack_rd_q <= stack_mem[idx_q];
	end

	// sequencer with output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			tr_q         <= '0;
			tc_q         <= '0;
			total_q      <= '0;
			depth_q      <= '0;
			idx_q        <= '0;
			trace_done_q <= 1'b0;
			m_tvalid_q   <= 1'b0;
			out_row_q    <= '0;
			out_col_q    <= '0;
			out_cost_q   <= '0;
			out_last_q   <= 1'b0;
		end else begin
			trace_done_q <= trace_end;
			// taken transaction leaves unless a new one loads
			if (m_tready && (state_q != ST_EMIT_LD)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						tr_q    <= job_row;
						tc_q    <= job_col;
						total_q <= job_cost;
						depth_q <= '0;
						state_q <= ST_TRACE_RD;
					end
				end
				ST_TRACE_RD: begin
					depth_q <= depth_q + DCW'(1);
					state_q <= ST_TRACE_CHK;
				end
				ST_TRACE_CHK: begin
					if (room && step_up) begin
						tr_q    <= tr_q - RW'(1);
						state_q <= ST_TRACE_RD;
					end else if (room && step_left) begin
						tc_q    <= tc_q - CW'(1);
						state_q <= ST_TRACE_RD;
					end else begin
						idx_q        <= PDW'(depth_q - DCW'(1));
						state_q      <= ST_EMIT_RD;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_LD;
				end
				ST_EMIT_LD: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						out_row_q  <= gmpst_pkg::COORD_W'(stack_rd_q[RW+CW-1:CW]);
						out_col_q  <= gmpst_pkg::COORD_W'(stack_rd_q[CW-1:0]);
						out_cost_q <= total_q;
						out_last_q <= (idx_q == '0);
						if (idx_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q - PDW'(1);
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: hdl/grid_min_path_sum_traceback_top.sv
// ----------------------------------------------------------------------------
// grid_min_path_sum_traceback_top: minimum path sum over a grid with traceback
// Cells arrive one per cycle in row-major order while s_tready is high. Each
// cell's cost is its value plus the cheaper of the up and left costs (left
// wins a tie); after the last cell the minimum path is sent from the origin
// to the bottom-right corner, each step carrying the total cost, the corner
// marked by tlast. The sweep takes one cell per clock when input is not held
// off, limited by the single cost add and compare. Once the last cell is in,
// the traceback walks the backpointer store, each path step a registered
// read of the store and then a decision, and input is held off until that
// walk ends; the walk starts later when the previous path is still being sent.
// The path is then sent from the path stack, each step a stack read and then
// an output register load, while the next grid's cells are already taken in.
// A write to either size register restarts the sweep at the origin; a size
// of 0 acts as 1 and a size above the maximum acts as the maximum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_min_path_sum_traceback_top #(
	parameter int MAX_ROWS = gmpst_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = gmpst_pkg::MAX_COLS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration: index 0 num_rows, index 1 num_cols
	input  logic                                cfg_we,
	input  logic [gmpst_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gmpst_pkg::CFG_W-1:0]         cfg_data,
	// input cells
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [gmpst_pkg::IN_TDATA_W-1:0]    s_tdata,   // [15:0] cell_value
	// path steps
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [gmpst_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [3:0] path_row, [7:4] path_col,
	                                                       // [28:8] total_cost, [31:29] zero
	output logic                                m_tlast    // is_last
);

	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int JW = gmpst_pkg::COST_W + RW + CW;
	localparam int PADW = gmpst_pkg::OUT_TDATA_W - 2 * gmpst_pkg::COORD_W - gmpst_pkg::COST_W;

	logic             push_valid;
	logic             push_ready;
	gmpst_pkg::cost_t push_cost;
	logic [RW-1:0]    push_row;
	logic [CW-1:0]    push_col;
	logic             pop_valid;
	logic             pop_ready;
	logic [JW-1:0]    pop_data;
	logic             trace_done;
	logic             bp_we;
	logic [RW+CW-1:0] bp_addr;
	gmpst_pkg::bp_t   bp_code;
	logic [gmpst_pkg::COORD_W-1:0] out_row;
	logic [gmpst_pkg::COORD_W-1:0] out_col;
	gmpst_pkg::cost_t out_cost;

	// sweep front end
	gmpst_front #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.job_valid  (push_valid),
		.job_ready  (push_ready),
		.job_cost   (push_cost),
		.job_row    (push_row),
		.job_col    (push_col),
		.trace_done (trace_done),
		.bp_we      (bp_we),
		.bp_addr    (bp_addr),
		.bp_code    (bp_code)
	);

	// job queue
	gmpst_queue #(
		.WIDTH(JW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  ({push_cost, push_row, push_col}),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// traceback back end
	gmpst_back #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.bp_we      (bp_we),
		.bp_addr    (bp_addr),
		.bp_code    (bp_code),
		.job_valid  (pop_valid),
		.job_ready  (pop_ready),
		.job_cost   (gmpst_pkg::cost_t'(pop_data[JW-1:RW+CW])),
		.job_row    (pop_data[RW+CW-1:CW]),
		.job_col    (pop_data[CW-1:0]),
		.trace_done (trace_done),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.out_row    (out_row),
		.out_col    (out_col),
		.out_cost   (out_cost),
		.out_last   (m_tlast)
	);

	// output packing
	assign m_tdata = {{PADW{1'b0}}, out_cost, out_col, out_row};

endmodule

// File: hdl/gmpst_checker.sv
// ----------------------------------------------------------------------------
// gmpst_checker: port-level checks for the grid path block
// Watches the path stream: handshake hold, a path starts at the origin,
// steps move right or down by one and the cost stays fixed along a path.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gmpst_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [gmpst_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                              m_tlast
);

	logic                          in_path_q;
	logic [gmpst_pkg::COORD_W-1:0] prev_row_q;
	logic [gmpst_pkg::COORD_W-1:0] prev_col_q;
	gmpst_pkg::cost_t              prev_cost_q;

	// track the previous transaction of the current path
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_path_q   <= 1'b0;
			prev_row_q  <= '0;
			prev_col_q  <= '0;
			prev_cost_q <= '0;
		end else if (m_tvalid && m_tready) begin
			in_path_q   <= !m_tlast;
			prev_row_q  <= m_tdata[3:0];
			prev_col_q  <= m_tdata[7:4];
			prev_cost_q <= m_tdata[28:8];
		end
	end

	// stalled transaction stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("path step dropped while stalled");

	// stalled payload holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("path step changed while stalled");

	// each path opens at the origin
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !in_path_q |-> m_tdata[7:0] == 8'd0)
		else $error("path does not start at the origin");

	// steps move one cell right or down
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && in_path_q |->
			(m_tdata[3:0] == prev_row_q + 4'd1 && m_tdata[7:4] == prev_col_q) ||
			(m_tdata[3:0] == prev_row_q && m_tdata[7:4] == prev_col_q + 4'd1))
		else $error("path step is not adjacent");

	// total cost is the same on every step of a path
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && in_path_q |-> m_tdata[28:8] == prev_cost_q)
		else $error("total cost changed within a path");

endmodule

bind grid_min_path_sum_traceback_top gmpst_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
